FILE: design/osr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osr_pkg
// Shared types, widths and codes for the over-power shutdown/retry block.
// ----------------------------------------------------------------------------
package osr_pkg;

    localparam int POWER_W  = 16;
    localparam int DETECT_W = 8;
    localparam int HOLD_W   = 16;
    localparam int STEP_W   = 2;
    localparam int EVENT_W  = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int MAX_TRIPS = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_POWER_LIMIT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATH_ON      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PROTECT_ON   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DETECT_FIRST = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DETECT_LATER = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_FIRST   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_SECOND  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_THIRD   = 3'd7;

    // request kinds
    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    // event codes; trip events 1..MAX_TRIPS are step + 1
    localparam logic [EVENT_W-1:0] EV_NONE    = 3'd0;
    localparam logic [EVENT_W-1:0] EV_TRIP1   = 3'd1;
    localparam logic [EVENT_W-1:0] EV_TRIP3   = 3'd3;
    localparam logic [EVENT_W-1:0] EV_FOREVER = 3'd4;
    localparam logic [EVENT_W-1:0] EV_RECOVER = 3'd5;

    typedef struct packed {
        logic signed [POWER_W-1:0] power_limit;
        logic                      path_on;
        logic                      protect_on;
        logic [DETECT_W-1:0]       detect_first;
        logic [DETECT_W-1:0]       detect_later;
        logic [HOLD_W-1:0]         hold_first;
        logic [HOLD_W-1:0]         hold_second;
        logic [HOLD_W-1:0]         hold_third;
    } cfg_t;

    typedef struct packed {
        logic                      kind;
        logic signed [POWER_W-1:0] output_power;
    } item_t;

    typedef struct packed {
        logic               amp_on;
        logic               alarm;
        logic [EVENT_W-1:0] event_res;
        logic [STEP_W-1:0]  trip_count;
    } result_t;

    typedef struct packed {
        logic                shut_flag;
        logic                forever_flag;
        logic [STEP_W-1:0]   step_count;
        logic [HOLD_W-1:0]   hold_count;
        logic [DETECT_W-1:0] detect_count;
        logic                alarm_bit;
        logic                amp_state;
    } path_state_t;

endpackage

FILE: design/osr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osr_if
// Valid/ready channels for tick requests and per-request results.
// ----------------------------------------------------------------------------
interface osr_item_if
    import osr_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic                      kind;
    logic signed [POWER_W-1:0] output_power;

    modport source (output valid, output kind, output output_power, input ready);
    modport sink   (input valid, input kind, input output_power, output ready);
endinterface

interface osr_result_if
    import osr_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               amp_on;
    logic               alarm;
    logic [EVENT_W-1:0] event_res;
    logic [STEP_W-1:0]  trip_count;

    modport source (output valid, output amp_on, output alarm, output event_res,
                    output trip_count, input ready);
    modport sink   (input valid, input amp_on, input alarm, input event_res,
                    input trip_count, output ready);
endinterface

FILE: design/osr_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osr_cfg_regs
// Configuration register file, write-only, written by index.
// ----------------------------------------------------------------------------
module osr_cfg_regs
    import osr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_POWER_LIMIT:  cfg_next.power_limit  = cfg_wdata[POWER_W-1:0];
                REG_PATH_ON:      cfg_next.path_on      = cfg_wdata[0];
                REG_PROTECT_ON:   cfg_next.protect_on   = cfg_wdata[0];
                REG_DETECT_FIRST: cfg_next.detect_first = cfg_wdata[DETECT_W-1:0];
                REG_DETECT_LATER: cfg_next.detect_later = cfg_wdata[DETECT_W-1:0];
                REG_HOLD_FIRST:   cfg_next.hold_first   = cfg_wdata[HOLD_W-1:0];
                REG_HOLD_SECOND:  cfg_next.hold_second  = cfg_wdata[HOLD_W-1:0];
                REG_HOLD_THIRD:   cfg_next.hold_third   = cfg_wdata[HOLD_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.power_limit  <= '0;
            cfg_reg.path_on      <= 1'b0;
            cfg_reg.protect_on   <= 1'b0;
            cfg_reg.detect_first <= DETECT_W'(6);
            cfg_reg.detect_later <= DETECT_W'(3);
            cfg_reg.hold_first   <= HOLD_W'(3);
            cfg_reg.hold_second  <= HOLD_W'(3);
            cfg_reg.hold_third   <= HOLD_W'(3);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: design/osr_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osr_step
// Path state and the combinational update that one request applies to it.
// ----------------------------------------------------------------------------
module osr_step
    import osr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    advance,
    input  item_t   item,
    output result_t res
);

    path_state_t st_reg;
    path_state_t st_next;
    logic [EVENT_W-1:0]  ev;
    logic [HOLD_W-1:0]   hold_inc;
    logic [HOLD_W-1:0]   hold_lim;
    logic [DETECT_W-1:0] det_inc;
    logic [DETECT_W-1:0] det_need;

    assign hold_inc = st_reg.hold_count + HOLD_W'(1);
    assign det_inc  = st_reg.detect_count + DETECT_W'(1);
    assign det_need = (st_reg.step_count == '0) ? cfg.detect_first : cfg.detect_later;

    always_comb
    begin
        case (st_reg.step_count)
            STEP_W'(1): hold_lim = cfg.hold_first;
            STEP_W'(2): hold_lim = cfg.hold_second;
            default:    hold_lim = cfg.hold_third;
        endcase
    end

    always_comb
    begin
        st_next = st_reg;
        ev      = EV_NONE;
        if (item.kind == KIND_CLEAR)
        begin
            // amp stays as it is until a later recovery
            st_next.shut_flag    = 1'b0;
            st_next.forever_flag = 1'b0;
            st_next.step_count   = '0;
            st_next.hold_count   = '0;
            st_next.detect_count = '0;
            st_next.alarm_bit    = 1'b0;
        end
        else if (cfg.path_on && cfg.protect_on && !st_reg.forever_flag)
        begin
            if (st_reg.shut_flag)
            begin
                if (st_reg.step_count >= STEP_W'(1) &&
                    st_reg.step_count <= STEP_W'(MAX_TRIPS))
                begin
                    if (hold_inc >= hold_lim)
                    begin
                        st_next.hold_count = '0;
                        st_next.shut_flag  = 1'b0;
                        st_next.alarm_bit  = 1'b0;
                        st_next.amp_state  = 1'b1;
                        ev                 = EV_RECOVER;
                    end
                    else
                    begin
                        st_next.hold_count = hold_inc;
                    end
                end
            end
            else if (item.output_power > cfg.power_limit)
            begin
                if (det_inc >= det_need)
                begin
                    st_next.detect_count = '0;
                    st_next.amp_state    = 1'b0;
                    st_next.alarm_bit    = 1'b1;
                    if (st_reg.step_count >= STEP_W'(MAX_TRIPS))
                    begin
                        st_next.forever_flag = 1'b1;
                        st_next.step_count   = '0;
                        ev                   = EV_FOREVER;
                    end
                    else
                    begin
                        ev                 = EVENT_W'(st_reg.step_count) + EVENT_W'(1);
                        st_next.shut_flag  = 1'b1;
                        st_next.hold_count = '0;
                        st_next.step_count = st_reg.step_count + STEP_W'(1);
                    end
                end
                else
                begin
                    st_next.detect_count = det_inc;
                end
            end
            else
            begin
                st_next.shut_flag    = 1'b0;
                st_next.forever_flag = 1'b0;
                st_next.step_count   = '0;
                st_next.hold_count   = '0;
                st_next.detect_count = '0;
                st_next.alarm_bit    = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.shut_flag    <= 1'b0;
            st_reg.forever_flag <= 1'b0;
            st_reg.step_count   <= '0;
            st_reg.hold_count   <= '0;
            st_reg.detect_count <= '0;
            st_reg.alarm_bit    <= 1'b0;
            st_reg.amp_state    <= 1'b1;
        end
        else if (advance)
        begin
            st_reg <= st_next;
        end
    end

    assign res.amp_on     = st_next.amp_state;
    assign res.alarm      = st_next.alarm_bit;
    assign res.event_res  = ev;
    assign res.trip_count = st_next.step_count;

endmodule

FILE: design/overpower_shutdown_retry_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// overpower_shutdown_retry_core
// Over-power protection for one amplifier path with timed retries.
// ----------------------------------------------------------------------------
// Takes one request per clock while the output is not stalled, and returns one
// result per request: a request is captured in the input register, the path
// state update and result are computed by counter/compare logic, and the result
// is held in the output register until taken. While a result waits, one more
// request can be taken into the input register. Configuration must be written
// only while no request is in flight.
module overpower_shutdown_retry_core
    import osr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    osr_item_if.sink              item,
    osr_result_if.source          result
);

    cfg_t    cfg;
    item_t   item_reg;
    logic    item_vld_reg;
    result_t res_reg;
    logic    res_vld_reg;
    result_t res_comb;
    logic    out_free;
    logic    advance;

    assign out_free   = !res_vld_reg || result.ready;
    assign advance    = item_vld_reg && out_free;
    assign item.ready = !item_vld_reg || advance;

    osr_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    osr_step u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .advance (advance),
        .item    (item_reg),
        .res     (res_comb)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg <= 1'b0;
            res_vld_reg  <= 1'b0;
        end
        else
        begin
            if (item.ready)
            begin
                item_vld_reg <= item.valid;
            end
            if (out_free)
            begin
                res_vld_reg <= advance;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            item_reg.kind         <= item.kind;
            item_reg.output_power <= item.output_power;
        end
        if (advance)
        begin
            res_reg <= res_comb;
        end
    end

    assign result.valid      = res_vld_reg;
    assign result.amp_on     = res_reg.amp_on;
    assign result.alarm      = res_reg.alarm;
    assign result.event_res  = res_reg.event_res;
    assign result.trip_count = res_reg.trip_count;

endmodule

FILE: design/osr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osr_checker
// Port-level checks on results of the over-power shutdown/retry block.
// ----------------------------------------------------------------------------
module osr_checker
    import osr_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               res_valid,
    input logic               res_ready,
    input logic               amp_on,
    input logic               alarm,
    input logic [EVENT_W-1:0] event_res,
    input logic [STEP_W-1:0]  trip_count
);

    // stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=>
            res_valid && $stable({amp_on, alarm, event_res, trip_count}))
        else $error("result changed while stalled");

    a_ev_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> event_res <= EV_RECOVER)
        else $error("undefined event code");

    // a trip turns the amp off, raises the alarm and reports its own step
    a_trip: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && event_res >= EV_TRIP1 && event_res <= EV_TRIP3 |->
            !amp_on && alarm && EVENT_W'(trip_count) == event_res)
        else $error("trip result inconsistent");

    a_recover: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && event_res == EV_RECOVER |-> amp_on && !alarm && trip_count != '0)
        else $error("recovery result inconsistent");

    a_forever: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && event_res == EV_FOREVER |-> !amp_on && alarm && trip_count == '0)
        else $error("permanent shutdown result inconsistent");

endmodule

bind overpower_shutdown_retry_core osr_checker u_osr_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .amp_on     (result.amp_on),
    .alarm      (result.alarm),
    .event_res  (result.event_res),
    .trip_count (result.trip_count)
);
